@@ rtl/cdad_pkg.sv @@
// package: constants and small tables for the calendar date offset pipeline
package cdad_pkg;

   // number of register stages, the output register included
   localparam int StageCount = 9;

   // inverse scheme divisors
   localparam logic [63:0] EraDays  = 64'd146097;
   localparam logic [63:0] CentDiv  = 64'd1461001;
   localparam logic [63:0] MonthDiv = 64'd2447;
   localparam logic [63:0] Hundred  = 64'd100;

   // reciprocal multipliers: floor(num * x / d) = (x * mul) >> shift over the used range
   localparam int          Recip100Shift = 22;
   localparam logic [15:0] Recip100Mul   =
      16'(((64'd1 << Recip100Shift) + Hundred - 64'd1) / Hundred);

   localparam int          RecipNShift = 42;
   localparam logic [26:0] RecipNMul   =
      27'(((64'd4 << RecipNShift) + EraDays - 64'd1) / EraDays);

   localparam int          RecipIShift = 37;
   localparam logic [28:0] RecipIMul   =
      29'(((64'd4000 << RecipIShift) + CentDiv - 64'd1) / CentDiv);

   localparam int          RecipJShift = 21;
   localparam logic [16:0] RecipJMul   =
      17'(((64'd80 << RecipJShift) + MonthDiv - 64'd1) / MonthDiv);

   // floor(367 * (m - 2 - 12a) / 12), a = -1 for months 0..2
   function automatic logic [8:0] month_term(input logic [3:0] m);
      logic [8:0] r;
      case (m)
         4'd0:    r = 9'd305;
         4'd1:    r = 9'd336;
         4'd2:    r = 9'd367;
         4'd3:    r = 9'd30;
         4'd4:    r = 9'd61;
         4'd5:    r = 9'd91;
         4'd6:    r = 9'd122;
         4'd7:    r = 9'd152;
         4'd8:    r = 9'd183;
         4'd9:    r = 9'd214;
         4'd10:   r = 9'd244;
         4'd11:   r = 9'd275;
         4'd12:   r = 9'd305;
         4'd13:   r = 9'd336;
         4'd14:   r = 9'd367;
         default: r = 9'd397;
      endcase
      return r;
   endfunction

   // floor(2447 * j / 80)
   function automatic logic [8:0] day_term(input logic [3:0] j);
      logic [8:0] r;
      case (j)
         4'd0:    r = 9'd0;
         4'd1:    r = 9'd30;
         4'd2:    r = 9'd61;
         4'd3:    r = 9'd91;
         4'd4:    r = 9'd122;
         4'd5:    r = 9'd152;
         4'd6:    r = 9'd183;
         4'd7:    r = 9'd214;
         4'd8:    r = 9'd244;
         4'd9:    r = 9'd275;
         4'd10:   r = 9'd305;
         4'd11:   r = 9'd336;
         4'd12:   r = 9'd367;
         4'd13:   r = 9'd397;
         4'd14:   r = 9'd428;
         default: r = 9'd458;
      endcase
      return r;
   endfunction

endpackage

@@ rtl/calendar_date_add_days.sv @@
// top level: gregorian date plus signed day offset through the julian day number
// an accepted req beat moves through the stage registers in order to its rsp beat
// throughput: one beat per cycle; the multiply stages set the depth, each pipe stage
//   holds one beat and empty stages fill even while the output register is stalled
// reset: synchronous, clears the stage valid bits only; payload registers are not reset
module calendar_date_add_days (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic signed [20:0] req_day_offset,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [13:0]        rsp_new_year,
   output logic [3:0]         rsp_new_month,
   output logic [4:0]         rsp_new_day,
   output logic [22:0]        rsp_day_number,
   output logic               rsp_out_of_range
);

   // stage valid bits and per-stage load enables
   logic [cdad_pkg::StageCount:1] v_ff, v_in, en;

   // a stage loads when it is empty or the stage after it moves on
   always_comb begin
      en[cdad_pkg::StageCount] = ~v_ff[cdad_pkg::StageCount] | ~rsp_stall;
      for (int k = cdad_pkg::StageCount - 1; k >= 1; k--) begin
         en[k] = ~v_ff[k] | en[k + 1];
      end
      v_in[1] = en[1] ? req_valid : v_ff[1];
      for (int k = 2; k <= cdad_pkg::StageCount; k++) begin
         v_in[k] = en[k] ? v_ff[k - 1] : v_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         v_ff <= v_in;
      end
   end

   assign req_stall = ~en[1];
   assign rsp_valid = v_ff[cdad_pkg::StageCount];

   // ---------------- stage 1: month fold, year offsets, day sum ----------------
   logic               a_neg;
   logic [14:0]        y1_in, y1_ff;
   logic [14:0]        x3_in, x3_ff;
   logic [8:0]         t2_in, t2_ff;
   logic signed [22:0] dk_in, dk_ff;

   always_comb begin
      // january and february (and month zero) count as months of the prior year
      a_neg = req_month < 4'd3;
      y1_in = {1'b0, req_year} + (a_neg ? 15'd4799 : 15'd4800);
      x3_in = {1'b0, req_year} + (a_neg ? 15'd4899 : 15'd4900);
      t2_in = cdad_pkg::month_term(req_month);
      // day plus offset with the fixed epoch constant folded in
      dk_in = $signed({{2{req_day_offset[20]}}, req_day_offset})
            + $signed({18'b0, req_day}) - 23'sd32075;
   end

   always_ff @(posedge clock) begin
      if (en[1]) begin
         y1_ff <= y1_in;
         x3_ff <= x3_in;
         t2_ff <= t2_in;
         dk_ff <= dk_in;
      end
   end

   // ---------------- stage 2: year and century products ----------------
   logic [24:0]        p1_in, p1_ff;
   logic [30:0]        p3_in, p3_ff;
   logic [8:0]         t2b_ff;
   logic signed [22:0] dkb_ff;

   always_comb begin
      p1_in = {10'b0, y1_ff} * 25'd1461;
      // century count through a reciprocal of 100
      p3_in = {16'b0, x3_ff} * {15'b0, cdad_pkg::Recip100Mul};
   end

   always_ff @(posedge clock) begin
      if (en[2]) begin
         p1_ff  <= p1_in;
         p3_ff  <= p3_in;
         t2b_ff <= t2_ff;
         dkb_ff <= dk_ff;
      end
   end

   // ---------------- stage 3: julian day number sum ----------------
   logic [22:0]        t1;
   logic [7:0]         cent;
   logic [9:0]         cent3;
   logic [7:0]         t3;
   logic signed [24:0] jdn_sum;
   logic [23:0]        jdn3_in, jdn3_ff;

   always_comb begin
      t1      = p1_ff[24:2];
      cent    = p3_ff[29:22];
      cent3   = {2'b0, cent} * 10'd3;
      t3      = cent3[9:2];
      jdn_sum = $signed({2'b0, t1}) + $signed({16'b0, t2b_ff})
              - $signed({17'b0, t3}) + $signed({{2{dkb_ff[22]}}, dkb_ff});
      // the sum is positive for every input pattern
      jdn3_in = jdn_sum[23:0];
   end

   always_ff @(posedge clock) begin
      if (en[3]) begin
         jdn3_ff <= jdn3_in;
      end
   end

   // ---------------- stage 4: 400-year era quotient product ----------------
   logic [23:0] l4_in, l4_ff;
   logic [50:0] pn_in, pn_ff;
   logic [23:0] jdn4_ff;

   always_comb begin
      l4_in = jdn3_ff + 24'd68569;
      pn_in = {27'b0, l4_in} * {24'b0, cdad_pkg::RecipNMul};
   end

   always_ff @(posedge clock) begin
      if (en[4]) begin
         l4_ff   <= l4_in;
         pn_ff   <= pn_in;
         jdn4_ff <= jdn3_ff;
      end
   end

   // ---------------- stage 5: remove whole eras ----------------
   logic [7:0]  n5_in, n5_ff;
   logic [25:0] era_days;
   logic [23:0] l2_full;
   logic [15:0] l25_in, l25_ff;
   logic [23:0] jdn5_ff;

   always_comb begin
      n5_in    = pn_ff[49:42];
      era_days = {18'b0, n5_in} * 26'd146097 + 26'd3;
      l2_full  = l4_ff - era_days[25:2];
      l25_in   = l2_full[15:0];
   end

   always_ff @(posedge clock) begin
      if (en[5]) begin
         n5_ff   <= n5_in;
         l25_ff  <= l25_in;
         jdn5_ff <= jdn4_ff;
      end
   end

   // ---------------- stage 6: year within era product ----------------
   logic [15:0] l2p1;
   logic [44:0] pi_in, pi_ff;
   logic [15:0] l26_ff;
   logic [7:0]  n6_ff;
   logic [23:0] jdn6_ff;

   always_comb begin
      l2p1  = l25_ff + 16'd1;
      pi_in = {29'b0, l2p1} * {16'b0, cdad_pkg::RecipIMul};
   end

   always_ff @(posedge clock) begin
      if (en[6]) begin
         pi_ff   <= pi_in;
         l26_ff  <= l25_ff;
         n6_ff   <= n5_ff;
         jdn6_ff <= jdn5_ff;
      end
   end

   // ---------------- stage 7: day within march-based year ----------------
   logic [6:0]  i7_in, i7_ff;
   logic [17:0] yr_days;
   logic [15:0] l3_full;
   logic [8:0]  l37_in, l37_ff;
   logic [7:0]  n7_ff;
   logic [23:0] jdn7_ff;

   always_comb begin
      i7_in   = pi_ff[43:37];
      yr_days = {11'b0, i7_in} * 18'd1461;
      l3_full = l26_ff - yr_days[17:2] + 16'd31;
      l37_in  = l3_full[8:0];
   end

   always_ff @(posedge clock) begin
      if (en[7]) begin
         i7_ff   <= i7_in;
         l37_ff  <= l37_in;
         n7_ff   <= n6_ff;
         jdn7_ff <= jdn6_ff;
      end
   end

   // ---------------- stage 8: month index product ----------------
   logic [25:0] pj_in, pj_ff;
   logic [8:0]  l38_ff;
   logic [6:0]  i8_ff;
   logic [7:0]  n8_ff;
   logic [23:0] jdn8_ff;

   always_comb begin
      pj_in = {17'b0, l37_ff} * {9'b0, cdad_pkg::RecipJMul};
   end

   always_ff @(posedge clock) begin
      if (en[8]) begin
         pj_ff   <= pj_in;
         l38_ff  <= l37_ff;
         i8_ff   <= i7_ff;
         n8_ff   <= n7_ff;
         jdn8_ff <= jdn7_ff;
      end
   end

   // ---------------- stage 9: date fields, range check, output register ----------------
   logic [3:0]  mj;
   logic        k_wrap;
   logic [3:0]  mon;
   logic [8:0]  day_full;
   logic [15:0] n_m49;
   logic [15:0] ny;
   logic        flag;
   logic [13:0] rsp_new_year_in, rsp_new_year_ff;
   logic [3:0]  rsp_new_month_in, rsp_new_month_ff;
   logic [4:0]  rsp_new_day_in, rsp_new_day_ff;
   logic [22:0] rsp_day_number_in, rsp_day_number_ff;
   logic        rsp_out_of_range_in, rsp_out_of_range_ff;

   always_comb begin
      mj       = pj_ff[24:21];
      // month indexes past december (january and february) roll into the next year
      k_wrap   = mj >= 4'd11;
      mon      = k_wrap ? (mj - 4'd10) : (mj + 4'd2);
      day_full = l38_ff - cdad_pkg::day_term(mj);
      // year in 16-bit two's complement, may run negative
      n_m49    = {8'b0, n8_ff} - 16'd49;
      ny       = n_m49 * 16'd100 + {9'b0, i8_ff} + {15'b0, k_wrap};
      flag     = ny[15] || (ny == 16'd0) || (ny > 16'd9999);
      if (flag) begin
         rsp_new_year_in   = '0;
         rsp_new_month_in  = '0;
         rsp_new_day_in    = '0;
         rsp_day_number_in = '0;
      end else begin
         rsp_new_year_in   = ny[13:0];
         rsp_new_month_in  = mon;
         rsp_new_day_in    = day_full[4:0];
         rsp_day_number_in = jdn8_ff[22:0];
      end
      rsp_out_of_range_in = flag;
   end

   always_ff @(posedge clock) begin
      if (en[9]) begin
         rsp_new_year_ff     <= rsp_new_year_in;
         rsp_new_month_ff    <= rsp_new_month_in;
         rsp_new_day_ff      <= rsp_new_day_in;
         rsp_day_number_ff   <= rsp_day_number_in;
         rsp_out_of_range_ff <= rsp_out_of_range_in;
      end
   end

   assign rsp_new_year     = rsp_new_year_ff;
   assign rsp_new_month    = rsp_new_month_ff;
   assign rsp_new_day      = rsp_new_day_ff;
   assign rsp_day_number   = rsp_day_number_ff;
   assign rsp_out_of_range = rsp_out_of_range_ff;

endmodule

@@ verif/date_shift_checker.sv @@
// checker: predicts each shifted date and compares result beats in order
`timescale 1ns / 1ps

module date_shift_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [13:0]        req_year,
   input  logic [3:0]         req_month,
   input  logic [4:0]         req_day,
   input  logic signed [20:0] req_day_offset,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [13:0]        rsp_new_year,
   input  logic [3:0]         rsp_new_month,
   input  logic [4:0]         rsp_new_day,
   input  logic [22:0]        rsp_day_number,
   input  logic               rsp_out_of_range,
   output int                 mismatch_count,
   output int                 dates_in_flight
);

   typedef struct packed {
      logic [13:0] year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [22:0] jdn;
      logic        flagged;
   } date_result_type;

   date_result_type awaited_dates[$];

   // truncating division throughout, as the block does
   function automatic date_result_type shift_date(input logic [13:0] y_in,
                                                  input logic [3:0] m_in,
                                                  input logic [4:0] d_in,
                                                  input logic signed [20:0] off_in);
      longint yy, mm, dd, a, jdn, l, n, i, j, k, ny, nm, nd;
      date_result_type r;
      yy  = longint'(y_in);
      mm  = longint'(m_in);
      dd  = longint'(d_in) + longint'(off_in);
      a   = (mm - 14) / 12;
      jdn = (1461 * (yy + 4800 + a)) / 4 + (367 * (mm - 2 - 12 * a)) / 12
            - (3 * ((yy + 4900 + a) / 100)) / 4 + dd - 32075;
      // back to a calendar date
      l  = jdn + 68569;
      n  = (4 * l) / 146097;
      l  = l - (146097 * n + 3) / 4;
      i  = (4000 * (l + 1)) / 1461001;
      l  = l - (1461 * i) / 4 + 31;
      j  = (80 * l) / 2447;
      nd = l - (2447 * j) / 80;
      k  = j / 11;
      nm = j + 2 - 12 * k;
      ny = 100 * (n - 49) + i + k;
      r = '0;
      if (ny < 1 || ny > 9999) begin
         r.flagged = 1'b1;
      end else begin
         r.year  = ny[13:0];
         r.month = nm[3:0];
         r.day   = nd[4:0];
         r.jdn   = jdn[22:0];
      end
      return r;
   endfunction

   task automatic note_mismatch(input string what, input longint got, input longint want);
      $display("%0t date check: %s got %0d want %0d", $realtime, what, got, want);
      mismatch_count++;
   endtask

   always @(posedge clock) begin : watch
      date_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            awaited_dates.insert(awaited_dates.size(),
                                 shift_date(req_year, req_month, req_day,
                                            req_day_offset));
         if (rsp_valid && !rsp_stall) begin
            if (awaited_dates.size() == 0) begin
               note_mismatch("result beat with nothing awaited", 0, 0);
            end else begin
               want = awaited_dates.pop_front();
               if (rsp_new_year !== want.year)
                  note_mismatch("new_year", rsp_new_year, want.year);
               if (rsp_new_month !== want.month)
                  note_mismatch("new_month", rsp_new_month, want.month);
               if (rsp_new_day !== want.day)
                  note_mismatch("new_day", rsp_new_day, want.day);
               if (rsp_day_number !== want.jdn)
                  note_mismatch("day_number", rsp_day_number, want.jdn);
               if (rsp_out_of_range !== want.flagged)
                  note_mismatch("out_of_range", rsp_out_of_range, want.flagged);
            end
         end
      end
      dates_in_flight <= awaited_dates.size();
   end

endmodule

@@ verif/calendar_date_add_days_test.sv @@
// testbench top: date offset stimulus, random back-pressure and the final verdict
`timescale 1ns / 1ps

module calendar_date_add_days_test;

   logic               clock = 1'b0;
   logic               reset;
   logic               req_valid;
   logic               req_stall;
   logic [13:0]        req_year;
   logic [3:0]         req_month;
   logic [4:0]         req_day;
   logic signed [20:0] req_day_offset;
   logic               rsp_valid;
   logic               rsp_stall;
   logic [13:0]        rsp_new_year;
   logic [3:0]         rsp_new_month;
   logic [4:0]         rsp_new_day;
   logic [22:0]        rsp_day_number;
   logic               rsp_out_of_range;

   int mismatch_count;
   int dates_in_flight;
   // chance of idling, shared by sender and receiver; zero gives a clean stretch
   int idle_odds;

   // 4 ns period
   always #2 clock = ~clock;

   calendar_date_add_days uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_year         (req_year),
      .req_month        (req_month),
      .req_day          (req_day),
      .req_day_offset   (req_day_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_year     (rsp_new_year),
      .rsp_new_month    (rsp_new_month),
      .rsp_new_day      (rsp_new_day),
      .rsp_day_number   (rsp_day_number),
      .rsp_out_of_range (rsp_out_of_range)
   );

   // watches both channels, predicts and compares
   date_shift_checker date_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_year         (req_year),
      .req_month        (req_month),
      .req_day          (req_day),
      .req_day_offset   (req_day_offset),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_new_year     (rsp_new_year),
      .rsp_new_month    (rsp_new_month),
      .rsp_new_day      (rsp_new_day),
      .rsp_day_number   (rsp_day_number),
      .rsp_out_of_range (rsp_out_of_range),
      .mismatch_count   (mismatch_count),
      .dates_in_flight  (dates_in_flight)
   );

   // hard stop, far beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   // result side back-pressure: stall bursts at random
   initial begin
      rsp_stall = 1'b0;
      forever begin
         @(posedge clock);
         if ($urandom_range(0, 399) < idle_odds) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 14)) @(posedge clock);
            rsp_stall <= 1'b0;
         end
      end
   end

   // one date beat; returns at the edge that accepts it
   task automatic send_date(input logic [13:0] y, input logic [3:0] m,
                            input logic [4:0] d, input logic signed [20:0] off);
      // optional gap before the beat, never dependent on stall
      if ($urandom_range(0, 99) < idle_odds) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_year       <= y;
      req_month      <= m;
      req_day        <= d;
      req_day_offset <= off;
      do @(posedge clock); while (req_stall);
   endtask

   // mostly real dates with offsets of mixed reach, plus edges of the year range and raw bits
   task automatic send_random_date();
      int                 kind;
      int                 span;
      logic [13:0]        y;
      logic [3:0]         m;
      logic [4:0]         d;
      logic signed [20:0] off;
      kind = $urandom_range(0, 99);
      if (kind < 65) begin
         y = 14'($urandom_range(1, 9999));
         m = 4'($urandom_range(1, 12));
         d = 5'($urandom_range(1, (m == 4'd2) ? 29 : 30 + (($urandom_range(0, 1)))));
         case ($urandom_range(0, 3))
            0:       span = 400;
            1:       span = 40000;
            2:       span = 400000;
            default: span = 0;
         endcase
         if (span == 0)
            off = 21'($urandom);
         else
            off = 21'(int'($urandom_range(0, 2 * span)) - span);
      end else if (kind < 80) begin
         // near year 1 or year 9999 so the flag trips on either side
         y = ($urandom_range(0, 1) != 0) ? 14'($urandom_range(1, 3))
                                         : 14'($urandom_range(9997, 9999));
         m = 4'($urandom_range(1, 12));
         d = 5'($urandom_range(1, 28));
         off = 21'(int'($urandom_range(0, 4000)) - 2000);
      end else begin
         // any bit pattern at all
         y   = 14'($urandom);
         m   = 4'($urandom);
         d   = 5'($urandom);
         off = 21'($urandom);
      end
      send_date(y, m, d, off);
   endtask

   task automatic random_run(input int count, input int odds);
      idle_odds = odds;
      repeat (count) send_random_date();
   endtask

   // hold the sender until every awaited result is back
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      // wait on the clock so the in-flight count includes the last accepted beat
      @(posedge clock);
      while (dates_in_flight != 0) @(posedge clock);
   endtask

   initial begin
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_year       = '0;
      req_month      = '0;
      req_day        = '0;
      req_day_offset = '0;
      idle_odds      = 20;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // directed: range ends, leap rules, odd field values, offset extremes
      send_date(14'd2000, 4'd1, 5'd1, 21'sd0);
      send_date(14'd1, 4'd1, 5'd1, 21'sd0);
      send_date(14'd1, 4'd1, 5'd1, -21'sd1);            // drops below year 1
      send_date(14'd9999, 4'd12, 5'd31, 21'sd0);
      send_date(14'd9999, 4'd12, 5'd31, 21'sd1);        // runs past year 9999
      send_date(14'd1, 4'd1, 5'd1, 21'sd1048575);       // largest offset
      send_date(14'd9999, 4'd12, 5'd31, -21'sd1048576); // most negative offset
      send_date(14'd2000, 4'd2, 5'd28, 21'sd1);         // leap day, 400-year rule
      send_date(14'd1900, 4'd3, 5'd1, -21'sd1);         // century without leap day
      send_date(14'd2024, 4'd12, 5'd31, 21'sd1);        // year rollover
      send_date(14'd0, 4'd0, 5'd0, 21'sd0);             // all fields zero
      send_date(14'd16383, 4'd15, 5'd31, 21'sd1048575); // all ones but the offset
      send_date(14'd0, 4'd6, 5'd15, -21'sd1048576);
      send_date(14'd2023, 4'd13, 5'd5, 21'sd0);         // months past december
      send_date(14'd2023, 4'd14, 5'd5, 21'sd0);
      send_date(14'd2023, 4'd15, 5'd5, 21'sd0);
      send_date(14'd2023, 4'd0, 5'd10, 21'sd0);         // month zero
      send_date(14'd2023, 4'd2, 5'd31, 21'sd0);         // day past month end
      send_date(14'd2023, 4'd4, 5'd0, 21'sd0);          // day zero
      send_date(14'd1582, 4'd10, 5'd15, -21'sd1);
      send_date(14'd12000, 4'd6, 5'd1, -21'sd1048576);  // too-large year pulled back in range
      send_date(14'd1, 4'd1, 5'd1, -21'sd1048576);      // falls far below year 1
      send_date(14'd2000, 4'd1, 5'd1, -21'sd1);
      send_date(14'd2000, 4'd7, 5'd31, 21'sd12345);

      // let the pipe empty completely before the random part
      wait_for_drain();

      random_run(400, 25);
      random_run(200, 0);   // back to back, no stalls
      random_run(300, 40);
      random_run(150, 0);   // quiet tail

      wait_for_drain();
      repeat (cdad_pkg::StageCount + 5) @(posedge clock);
      if (mismatch_count == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
